@@ hw/rtl/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
`timescale 1ns / 1ps

package lr_pkg;

  // Field widths
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned LIN_W      = 13;  // x + y*width before wrap
  localparam int unsigned AREA_W     = 14;  // width*height
  localparam int unsigned ERR_W      = 9;   // doubled error term, signed
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // Defaults
  localparam int unsigned LR_MAX_SIDE = 64;
  localparam logic [DIM_W-1:0] IMG_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0] IMG_HEIGHT_RST = 7'd64;

  // Register indexes
  localparam logic [0:0] CFG_IMG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMG_HEIGHT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // take the input item and set up the stepper
    logic step;  // emit the current pixel and advance
  } lr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;      // current pixel ends the line
    logic out_free;  // output register can take a pixel this cycle
  } lr_sts_t;

endpackage

@@ hw/rtl/lr_ctrl.sv @@
// Controller state machine for the line rasterizer.
`timescale 1ns / 1ps

module lr_ctrl
  import lr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  lr_sts_t sts,
  output lr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Commands and handshake
  always_comb begin
    in_tready = (state_r == S_IDLE);
    cmd.load  = (state_r == S_IDLE) && in_tvalid;
    cmd.step  = (state_r == S_RUN) && sts.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (sts.out_free && sts.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/lr_dp.sv @@
// Datapath for the line rasterizer: setup, error-term stepper, address and output register.
`timescale 1ns / 1ps

module lr_dp
  import lr_pkg::*;
#(
  parameter int unsigned MAX_SIDE = LR_MAX_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lr_cmd_t               cmd,
  output lr_sts_t               sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [DIM_W-1:0]      cfg_wdata
);

  localparam int unsigned CNT_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  // Configuration
  logic [DIM_W-1:0]  width_r, height_r;
  logic [AREA_W-1:0] area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMG_WIDTH_RST;
      height_r <= IMG_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMG_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // image area, registered after the multiply
  always_ff @(posedge clk) begin
    area_r <= width_r * height_r;
  end

  // Setup from the incoming endpoints
  logic [COORD_W-1:0] ax, ay, bx, by, adx, ady;
  logic [COORD_W-1:0] ma0, ma1, mi0, mi1;
  logic [COORD_W-1:0] sa, se, ya, yb, dx, dy;
  logic               steep, swap, yneg;

  always_comb begin
    ax    = in_tdata[5:0];
    ay    = in_tdata[11:6];
    bx    = in_tdata[17:12];
    by    = in_tdata[23:18];
    adx   = (bx > ax) ? bx - ax : ax - bx;
    ady   = (by > ay) ? by - ay : ay - by;
    steep = ady > adx;
    ma0   = steep ? ay : ax;
    mi0   = steep ? ax : ay;
    ma1   = steep ? by : bx;
    mi1   = steep ? bx : by;
    swap  = ma0 > ma1;
    sa    = swap ? ma1 : ma0;
    se    = swap ? ma0 : ma1;
    ya    = swap ? mi1 : mi0;
    yb    = swap ? mi0 : mi1;
    dx    = se - sa;
    dy    = (yb > ya) ? yb - ya : ya - yb;
    yneg  = !(ya < yb);
  end

  // Stepper state
  logic [COORD_W-1:0]       x_r, xend_r, y_r, dx_r, dy_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     yneg_r, steep_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [3*COLOR_W-1:0]     color_r;

  // One Bresenham step
  logic signed [ERR_W-1:0] err_sub, err_nxt;
  logic [COORD_W-1:0]      y_nxt;
  logic                    last;

  always_comb begin
    err_sub = err_r - $signed({2'b00, dy_r, 1'b0});
    if (err_sub < 0) begin
      err_nxt = err_sub + $signed({2'b00, dx_r, 1'b0});
      y_nxt   = yneg_r ? y_r - 6'd1 : y_r + 6'd1;
    end else begin
      err_nxt = err_sub;
      y_nxt   = y_r;
    end
    last = (x_r == xend_r) || (cnt_r == CNT_W'(MAX_SIDE - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= sa;
      xend_r  <= se;
      y_r     <= ya;
      dx_r    <= dx;
      dy_r    <= dy;
      err_r   <= $signed({3'b000, dx});
      yneg_r  <= yneg;
      steep_r <= steep;
      cnt_r   <= '0;
      color_r <= in_tdata[47:24];
    end else if (cmd.step) begin
      x_r   <= x_r + 6'd1;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Pixel coordinates, linear address and clip
  logic [COORD_W-1:0] px, py;
  logic [LIN_W-1:0]   lin;
  logic               we;

  always_comb begin
    px  = steep_r ? y_r : x_r;
    py  = steep_r ? x_r : y_r;
    lin = LIN_W'(px) + LIN_W'(py * width_r);
    we  = AREA_W'(lin) < area_r;
  end

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_we_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data_r <= {color_r, lin[ADDR_W-1:0], py, px};
      out_we_r   <= we;
      out_last_r <= last;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_we_r;
  assign out_tlast    = out_last_r;
  assign sts.last     = last;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

@@ hw/rtl/line_rasterizer_top.sv @@
// Top level of the Bresenham line rasterizer.
`timescale 1ns / 1ps

// Takes one line (two 6-bit endpoints and an RGB color) per input item and
// emits one pixel write item per step along the major axis, lowest major
// coordinate first, with tlast on the final pixel. A line spanning N pixels
// on its major axis (capped at MAX_SIDE) is taken and the stepper set up;
// then the single error-term stepper emits one pixel a cycle unless the
// output side stalls. The next item is taken once the last pixel sits in
// the output register. write_enable is 0 when x + y*img_width is not
// below img_width*img_height; pixels are never dropped, and pix_addr wraps
// at 4096. Registers must be written only while idle; not enforced here.

module line_rasterizer_top
  import lr_pkg::*;
#(
  parameter int unsigned MAX_SIDE = LR_MAX_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18],
  // red_in[31:24], green_in[39:32], blue_in[47:40]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pix_x[5:0], pix_y[11:6], pix_addr[23:12],
  // red_out[31:24], green_out[39:32], blue_out[47:40]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // write_enable[0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [DIM_W-1:0]      cfg_wdata
);

  lr_cmd_t dp_cmd;
  lr_sts_t dp_sts;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  lr_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

`ifndef SYNTH
  // a taken line keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after taking a line");

  // emitting the last pixel reopens the input
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.step && dp_sts.last |=> in_tready)
    else $error("input not ready after last pixel");

  // a pixel is only emitted into a free output register
  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.step |-> (!out_tvalid || out_tready))
    else $error("pixel overwrote a held output item");
`endif

endmodule

@@ tb/line_rasterizer_checker.sv @@
// Scoreboard for the line rasterizer: predicts every pixel item and checks it.
`timescale 1ns / 1ps

module line_rasterizer_checker
  import lr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [DIM_W-1:0]      cfg_wdata,
  output int                    pixels_left,
  output int                    error_count
);

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ADDR_W-1:0]  addr;
    logic               we;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic               last;
  } pixel_t;

  // Shadow copy of the image size registers
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;

  pixel_t pixels_due[$];
  pixel_t want;

  initial begin
    pixels_left = 0;
    error_count = 0;
  end

  // One line per error
  task automatic log_error(input string msg);
    $display("%0t: pixel check: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val) begin
      log_error($sformatf("%s is %0d, expected %0d", name, got, exp_val));
    end
  endtask

  // Bresenham stepper with the doubled error term; queues one pixel per major step
  task automatic trace_line(input logic [IN_DATA_W-1:0] word);
    int          ax, ay, bx, by, tmp;
    int          dx, dy, err, ystep, xi, yi, n;
    int unsigned lin, area;
    bit          steep;
    pixel_t      p;
    ax = int'(word[5:0]);
    ay = int'(word[11:6]);
    bx = int'(word[17:12]);
    by = int'(word[23:18]);
    steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
    if (steep) begin
      tmp = ax; ax = ay; ay = tmp;
      tmp = bx; bx = by; by = tmp;
    end
    // major coordinate runs upward
    if (ax > bx) begin
      tmp = ax; ax = bx; bx = tmp;
      tmp = ay; ay = by; by = tmp;
    end
    dx    = bx - ax;
    dy    = (by > ay) ? by - ay : ay - by;
    err   = dx;
    ystep = (ay < by) ? 1 : -1;
    yi    = ay;
    n     = 0;
    area  = int'(img_w) * int'(img_h);
    for (xi = ax; xi <= bx && n < LR_MAX_SIDE; xi++) begin
      p.x    = steep ? yi[COORD_W-1:0] : xi[COORD_W-1:0];
      p.y    = steep ? xi[COORD_W-1:0] : yi[COORD_W-1:0];
      lin    = int'(p.x) + int'(p.y) * int'(img_w);
      p.addr = lin[ADDR_W-1:0];
      // full sum against full product is the only clip
      p.we   = (lin < area);
      p.r    = word[31:24];
      p.g    = word[39:32];
      p.b    = word[47:40];
      p.last = (xi == bx) || (n == LR_MAX_SIDE - 1);
      pixels_due.push_back(p);
      n++;
      err -= 2 * dy;
      if (err < 0) begin
        yi  += ystep;
        err += 2 * dx;
      end
    end
  endtask

  // Watch config writes, line items and pixel items
  always @(posedge clk) begin
    if (!rst_n) begin
      img_w = IMG_WIDTH_RST;
      img_h = IMG_HEIGHT_RST;
      pixels_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IMG_WIDTH:  img_w = cfg_wdata;
          CFG_IMG_HEIGHT: img_h = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pixels_due.size() == 0) begin
          log_error("pixel item with no line pending");
        end else begin
          want = pixels_due.pop_front();
          check_field("pix_x", int'(out_tdata[5:0]), int'(want.x));
          check_field("pix_y", int'(out_tdata[11:6]), int'(want.y));
          check_field("pix_addr", int'(out_tdata[23:12]), int'(want.addr));
          check_field("write_enable", int'(out_tuser), int'(want.we));
          check_field("red_out", int'(out_tdata[31:24]), int'(want.r));
          check_field("green_out", int'(out_tdata[39:32]), int'(want.g));
          check_field("blue_out", int'(out_tdata[47:40]), int'(want.b));
          check_field("last_pixel", int'(out_tlast), int'(want.last));
        end
      end
      if (in_tvalid && in_tready) begin
        trace_line(in_tdata);
      end
    end
    pixels_left = pixels_due.size();
  end

endmodule

@@ tb/tb_line_rasterizer_top.sv @@
// Testbench top for the line rasterizer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_line_rasterizer_top
  import lr_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned LINES_PER_PHASE = 45;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [0:0]            cfg_index = CFG_IMG_WIDTH;
  logic [DIM_W-1:0]      cfg_wdata = '0;

  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int          pixels_left;
  int          error_count;
  int unsigned cycles = 0;

  always #10 clk = ~clk;

  line_rasterizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  line_rasterizer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pixels_left(pixels_left),
    .error_count(error_count)
  );

  // Offer one line item after a random gap, hold it until taken
  task automatic send_line(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                           input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                           input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                           input logic [COLOR_W-1:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {b, g, r, ye, xe, ys, xs};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Both size registers, back to back; call only while idle
  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMG_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= CFG_IMG_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stop offering and wait until every predicted pixel came out
  task automatic drain;
    in_tvalid <= 1'b0;
    wait (pixels_left == 0);
    repeat (4) @(negedge clk);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int               kind, d, xs, ys, xe, ye;
    logic [DIM_W-1:0] w, h;
    logic [COLOR_W-1:0] r, g, b;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines at the reset image size
    send_line(6'd0, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);     // single pixel at origin
    send_line(6'd63, 6'd63, 6'd63, 6'd63, 8'hFF, 8'hFF, 8'hFF); // single pixel at far corner
    send_line(6'd0, 6'd0, 6'd63, 6'd0, 8'hAA, 8'h55, 8'hAA);    // full horizontal
    send_line(6'd63, 6'd63, 6'd0, 6'd63, 8'h55, 8'hAA, 8'h55);  // horizontal, reversed
    send_line(6'd0, 6'd0, 6'd0, 6'd63, 8'hFF, 8'h00, 8'hFF);    // full vertical
    send_line(6'd63, 6'd63, 6'd63, 6'd0, 8'h00, 8'hFF, 8'h00);  // vertical, reversed
    send_line(6'd0, 6'd0, 6'd63, 6'd63, 8'h12, 8'h34, 8'h56);   // main diagonal
    send_line(6'd0, 6'd63, 6'd63, 6'd0, 8'h80, 8'h01, 8'hFE);   // anti-diagonal
    send_line(6'd63, 6'd0, 6'd0, 6'd63, 8'h7F, 8'h80, 8'h01);   // anti-diagonal, reversed
    send_line(6'd10, 6'd0, 6'd12, 6'd63, 8'h01, 8'h02, 8'h04);  // steep
    send_line(6'd12, 6'd63, 6'd10, 6'd0, 8'h08, 8'h10, 8'h20);  // steep, reversed
    send_line(6'd0, 6'd5, 6'd63, 6'd7, 8'h40, 8'h80, 8'hC3);    // shallow
    send_line(6'd63, 6'd7, 6'd0, 6'd5, 8'h3C, 8'hE7, 8'h18);    // shallow, reversed
    send_line(6'd5, 6'd5, 6'd20, 6'd12, 8'h9A, 8'hBC, 8'hDE);
    send_line(6'd20, 6'd12, 6'd5, 6'd5, 8'hDE, 8'hBC, 8'h9A);
    send_line(6'd30, 6'd40, 6'd31, 6'd41, 8'h11, 8'h22, 8'h33); // two pixels, diagonal
    send_line(6'd30, 6'd40, 6'd31, 6'd40, 8'h44, 8'h55, 8'h66); // two pixels, flat
    send_line(6'd17, 6'd33, 6'd17, 6'd33, 8'h77, 8'h88, 8'h99); // single pixel mid image
    send_line(6'd0, 6'd63, 6'd1, 6'd0, 8'hE0, 8'h0E, 8'hF0);    // steep, one minor step
    send_line(6'd42, 6'd21, 6'd21, 6'd42, 8'h0F, 8'hF0, 8'h5A);
    drain;

    // random phases, each with its own image size
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = 7'd64;  h = 7'd64;  end
        1: begin w = 7'd1;   h = 7'd1;   end
        2: begin w = 7'd64;  h = 7'd1;   end
        3: begin w = 7'd1;   h = 7'd64;  end
        4: begin w = 7'd0;   h = 7'd64;  end
        5: begin w = 7'd64;  h = 7'd0;   end
        6: begin w = 7'd127; h = 7'd127; end
        7: begin w = 7'd37;  h = 7'd23;  end
        8: begin
          w = 7'($urandom_range(1, 64));
          h = 7'($urandom_range(1, 64));
        end
        default: begin
          w = 7'($urandom_range(0, 127));
          h = 7'($urandom_range(0, 127));
        end
      endcase
      set_image(w, h);
      no_idle = (p == 3 || p == 7);
      for (int i = 0; i < LINES_PER_PHASE; i++) begin
        if (p == 2 && i == 5) hold_req = 1'b1;
        kind = $urandom_range(0, 9);
        xs = $urandom_range(0, 63);
        ys = $urandom_range(0, 63);
        xe = $urandom_range(0, 63);
        ye = $urandom_range(0, 63);
        r  = 8'($urandom);
        g  = 8'($urandom);
        b  = 8'($urandom);
        case (kind)
          4: begin
            // short line near the start point
            xe = xs + $urandom_range(0, 8) - 4;
            ye = ys + $urandom_range(0, 8) - 4;
            if (xe < 0) xe = 0;
            if (xe > 63) xe = 63;
            if (ye < 0) ye = 0;
            if (ye > 63) ye = 63;
          end
          5: ye = ys;
          6: xe = xs;
          7: begin
            // exact 45 degree line
            d = (xe > xs) ? xe - xs : xs - xe;
            if ($urandom_range(0, 1) == 1) begin
              ys = $urandom_range(0, 63 - d);
              ye = ys + d;
            end else begin
              ys = $urandom_range(d, 63);
              ye = ys - d;
            end
          end
          8: begin
            xe = xs;
            ye = ys;
          end
          9: begin
            // corners with saturated colors
            xs = $urandom_range(0, 1) * 63;
            ys = $urandom_range(0, 1) * 63;
            xe = $urandom_range(0, 1) * 63;
            ye = $urandom_range(0, 1) * 63;
            r  = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            g  = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            b  = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
          end
          default: ;
        endcase
        send_line(6'(xs), 6'(ys), 6'(xe), 6'(ye), r, g, b);
      end
      drain;
    end

    repeat (16) @(negedge clk);
    if (error_count == 0) begin
      $display("[line_rasterizer_top] OK");
    end else begin
      $display("[line_rasterizer_top] ERROR");
    end
    $finish;
  end

  // Pixel sink: random ready gaps, one long hold-off to back up the input
  initial begin : receiver
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Run limit
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[line_rasterizer_top] ERROR");
    $finish;
  end

endmodule
